[sv/escaped_frame_receiver_crc16_top_assert.svh]
// Assertion macros for the escaped frame receiver.
// Depends on clk and arst_n being visible at the point of use.
`ifndef ESCAPED_FRAME_RECEIVER_CRC16_TOP_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC16_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EFR_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("efr: implication check failed");
`define EFR_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("efr: next-cycle check failed");
`else
`define EFR_ASSERT_IMPL(label, pre, post)
`define EFR_ASSERT_NEXT(label, pre, post)
`endif
`endif

[sv/efr_pkg.sv]
// Shared types and constants for the escaped frame receiver.
// No dependencies.
package efr_pkg;
	localparam int MAX_FRAME_BYTES_DEF = 256;
	localparam int HEADER_BYTES        = 3;
	localparam int MIN_FRAME           = 4;
	localparam int IDX_W               = 9;

	localparam logic [7:0]  MARK_BYTE = 8'hFF;
	localparam logic [7:0]  ESC_BYTE  = 8'hFE;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	localparam logic REG_ID_LIMIT   = 1'b0;
	localparam logic REG_DISP_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		EV_DATA = 2'd0,
		EV_GOOD = 2'd1,
		EV_BAD  = 2'd2
	} evt_t;

	typedef struct packed {
		evt_t             evt;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       frame_id;
		logic [7:0]       frame_display;
		logic [7:0]       payload_length;
	} result_t;

	typedef struct packed {
		logic hunting;
		logic escape_pending;
	} status_t;
endpackage

[sv/efr_crc16.sv]
// One-byte CRC-16/MODBUS update (reflected, poly 0xA001).
// Depends on efr_pkg.
module efr_crc16 import efr_pkg::*; (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end
endmodule

[sv/efr_core.sv]
// Deframing state, unescape, header capture and verdict for one byte per step.
// Depends on efr_pkg and efr_crc16.
module efr_core import efr_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic [7:0] id_limit,
	input  logic [7:0] display_limit,
	output logic       res_valid,
	output result_t    res,
	output status_t    status
);
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	logic             hunting_q, esc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      crc_q;
	logic [7:0]       hdr_id_q, hdr_disp_q, hdr_len_q;

	logic             hunting_d, esc_d;
	logic [CNT_W-1:0] cnt_d;
	logic [15:0]      crc_d, crc_fold;
	logic [7:0]       hdr_id_d, hdr_disp_d, hdr_len_d;
	logic [7:0]       plain;
	logic             good;

	assign plain = esc_q ? ~rx_byte : rx_byte;

	efr_crc16 u_crc (
		.crc_in (crc_q),
		.data   (plain),
		.crc_out(crc_fold)
	);

	assign good = (hdr_id_q < id_limit) && (hdr_disp_q < display_limit) && (crc_q == 16'h0000)
		&& (CMP_W'(cnt_q) == CMP_W'(hdr_len_q) + CMP_W'(HEADER_BYTES + 2));

	always_comb begin
		hunting_d  = hunting_q;
		esc_d      = esc_q;
		cnt_d      = cnt_q;
		crc_d      = crc_q;
		hdr_id_d   = hdr_id_q;
		hdr_disp_d = hdr_disp_q;
		hdr_len_d  = hdr_len_q;
		res_valid  = 1'b0;
		res        = '0;
		res.evt    = EV_DATA;
		if (hunting_q) begin
			if (rx_byte == MARK_BYTE) begin
				hunting_d = 1'b0;
				esc_d     = 1'b0;
				cnt_d     = '0;
				crc_d     = CRC_INIT;
			end
		end else if (rx_byte == MARK_BYTE) begin
			// end mark; a short frame just restarts without hunting
			esc_d = 1'b0;
			cnt_d = '0;
			crc_d = CRC_INIT;
			if (cnt_q >= CNT_W'(MIN_FRAME)) begin
				hunting_d          = 1'b1;
				res_valid          = 1'b1;
				res.evt            = good ? EV_GOOD : EV_BAD;
				res.frame_id       = hdr_id_q;
				res.frame_display  = hdr_disp_q;
				res.payload_length = hdr_len_q;
			end
		end else if (rx_byte == ESC_BYTE) begin
			esc_d = 1'b1;
		end else begin
			esc_d = 1'b0;
			if (cnt_q >= CNT_W'(MAX_FRAME_BYTES)) begin
				hunting_d = 1'b1;
			end else begin
				if (cnt_q == CNT_W'(0)) hdr_id_d = plain;
				if (cnt_q == CNT_W'(1)) hdr_disp_d = plain;
				if (cnt_q == CNT_W'(2)) hdr_len_d = plain;
				crc_d          = crc_fold;
				cnt_d          = cnt_q + CNT_W'(1);
				res_valid      = 1'b1;
				res.data_byte  = plain;
				res.byte_index = IDX_W'(cnt_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q  <= 1'b1;
			esc_q      <= 1'b0;
			cnt_q      <= '0;
			crc_q      <= CRC_INIT;
			hdr_id_q   <= '0;
			hdr_disp_q <= '0;
			hdr_len_q  <= '0;
		end else if (step) begin
			hunting_q  <= hunting_d;
			esc_q      <= esc_d;
			cnt_q      <= cnt_d;
			crc_q      <= crc_d;
			hdr_id_q   <= hdr_id_d;
			hdr_disp_q <= hdr_disp_d;
			hdr_len_q  <= hdr_len_d;
		end
	end

	assign status.hunting        = hunting_q;
	assign status.escape_pending = esc_q;
endmodule

[sv/efr_out_reg.sv]
// Result register on the master side; holds a beat until it is taken.
// Depends on efr_pkg.
module efr_out_reg import efr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    m_tready,
	output logic    m_tvalid,
	output result_t res_q
);
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
endmodule

[sv/escaped_frame_receiver_crc16_top.sv]
// Top level of the escaped frame receiver with CRC-16/MODBUS check.
// Depends on efr_pkg, efr_core, efr_out_reg and the assertion header.
//
// Slave stream: one raw serial byte per beat in s_tdata.
// Master stream: one result per beat; m_tuser is the event (data byte,
// frame good, frame bad), m_tdata carries the byte, its index and the
// header bytes of a finished frame.
// APB: register 0 id_limit at 0x0, register 1 display_limit at 0x4.
// Write limits only while the block is idle.
//
// Path: an accepted input beat passes the input register, then the result
// register, before its result is on m_tvalid. Throughput: one byte per
// cycle while the result register is free or m_tready is high, set by the
// single input stage feeding the deframer and CRC update, which are combinational.
// Bytes that cause no result (hunting, escape marks, short frames,
// overflow) still wait for the result register to be free.
// Reset: hunting for a start mark, CRC 0xFFFF, both limits 255.
// Stall: when m_tready is low the result register holds its beat and the
// input stage holds one more byte; s_tready drops once both are full.
module escaped_frame_receiver_crc16_top import efr_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] data_byte, [16:8] byte_index, [24:17] frame_id,
	                               // [32:25] frame_display, [40:33] payload_length, rest zero
	output logic [1:0]  m_tuser,   // [1:0] event_res
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	`include "escaped_frame_receiver_crc16_top_assert.svh"

	logic       s1_valid;
	logic [7:0] s1_byte;
	logic       advance;
	logic       res_valid;
	result_t    res, res_q;
	status_t    status;
	logic [7:0] id_limit_q, disp_limit_q;
	logic       cfg_wr;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_limit_q   <= 8'hFF;
			disp_limit_q <= 8'hFF;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ID_LIMIT:   id_limit_q   <= pwdata[7:0];
				REG_DISP_LIMIT: disp_limit_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ID_LIMIT:   prdata = {24'h0, id_limit_q};
			REG_DISP_LIMIT: prdata = {24'h0, disp_limit_q};
			default:        prdata = '0;
		endcase
	end

	// input stage
	assign advance  = s1_valid && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_byte <= s_tdata;
		end
	end

	efr_core #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.rx_byte      (s1_byte),
		.id_limit     (id_limit_q),
		.display_limit(disp_limit_q),
		.res_valid    (res_valid),
		.res          (res),
		.status       (status)
	);

	efr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && res_valid),
		.res     (res),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.res_q   (res_q)
	);

	assign m_tuser = res_q.evt;
	assign m_tdata = {7'h00, res_q.payload_length, res_q.frame_display, res_q.frame_id,
		res_q.byte_index, res_q.data_byte};

	// a verdict only comes from an end mark seen outside hunting
	`EFR_ASSERT_IMPL(a_verdict_on_mark, s1_valid && res_valid && (res.evt != EV_DATA), (s1_byte == MARK_BYTE) && !status.hunting)
	// stored bytes never index past the frame buffer size
	`EFR_ASSERT_IMPL(a_index_in_range, s1_valid && res_valid && (res.evt == EV_DATA), res.byte_index < IDX_W'(MAX_FRAME_BYTES) || MAX_FRAME_BYTES > 511)
	// a byte waiting in the input stage is not lost or changed
	`EFR_ASSERT_NEXT(a_s1_holds, s1_valid && !advance, s1_valid && $stable(s1_byte))
	// an accepted verdict sends the deframer back to hunting
	`EFR_ASSERT_NEXT(a_hunt_after_verdict, advance && res_valid && (res.evt != EV_DATA), status.hunting && !status.escape_pending)
endmodule

[tb/efr_frame_checker.sv]
// Scoreboard for the escaped frame receiver: watches the byte stream, the APB writes
// and the result stream, predicts each result and compares it field by field.
// Depends on efr_pkg.
module efr_frame_checker import efr_pkg::*; #(
	parameter int MAX_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          failures,
	output int          pending
);
	typedef struct {
		evt_t             evt;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       frame_id;
		logic [7:0]       frame_display;
		logic [7:0]       payload_length;
	} deframed_t;

	deframed_t   deframed_q[$];
	logic        hunting;
	logic        esc_pending;
	int unsigned stored_cnt;
	logic [15:0] crc_acc;
	logic [7:0]  hdr_id, hdr_disp, hdr_len;
	logic [7:0]  id_lim, disp_lim;
	int          fail_cnt = 0;

	assign failures = fail_cnt;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic restart_frame();
		stored_cnt  = 0;
		crc_acc     = CRC_INIT;
		esc_pending = 1'b0;
	endtask

	task automatic deframe_byte(input logic [7:0] raw);
		deframed_t res;
		logic [7:0] b;
		res = '{evt: EV_DATA, data_byte: 8'h00, byte_index: '0, frame_id: 8'h00,
			frame_display: 8'h00, payload_length: 8'h00};
		b = raw;
		if (hunting) begin
			if (b == MARK_BYTE) begin
				hunting = 1'b0;
				restart_frame();
			end
		end else if (b == MARK_BYTE) begin
			esc_pending = 1'b0;
			if (stored_cnt >= MIN_FRAME) begin
				res.evt = (hdr_id < id_lim && hdr_disp < disp_lim &&
					stored_cnt == hdr_len + HEADER_BYTES + 2 && crc_acc == 16'h0000) ?
					EV_GOOD : EV_BAD;
				res.frame_id       = hdr_id;
				res.frame_display  = hdr_disp;
				res.payload_length = hdr_len;
				deframed_q.push_back(res);
				hunting = 1'b1;
			end
			restart_frame();
		end else if (b == ESC_BYTE) begin
			esc_pending = 1'b1;
		end else begin
			if (esc_pending) begin
				b = ~b;
				esc_pending = 1'b0;
			end
			if (stored_cnt >= MAX_BYTES) begin
				// overflow: byte dropped, back to hunting with the count left as is
				hunting = 1'b1;
			end else begin
				case (stored_cnt)
					0: hdr_id   = b;
					1: hdr_disp = b;
					2: hdr_len  = b;
					default: ;
				endcase
				crc_acc        = crc_fold(crc_acc, b);
				res.data_byte  = b;
				res.byte_index = stored_cnt[IDX_W-1:0];
				deframed_q.push_back(res);
				stored_cnt++;
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic check_beat();
		deframed_t want;
		if (deframed_q.size() == 0) begin
			$error("unexpected result beat: event %0d, tdata 0x%0h", m_tuser, m_tdata);
			fail_cnt++;
		end else begin
			want = deframed_q.pop_front();
			check_field("event_res", want.evt, m_tuser);
			check_field("data_byte", want.data_byte, m_tdata[7:0]);
			check_field("byte_index", want.byte_index, m_tdata[16:8]);
			check_field("frame_id", want.frame_id, m_tdata[24:17]);
			check_field("frame_display", want.frame_display, m_tdata[32:25]);
			check_field("payload_length", want.payload_length, m_tdata[40:33]);
			check_field("tdata_pad", 0, m_tdata[47:41]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deframed_q.delete();
			hunting  = 1'b1;
			restart_frame();
			hdr_id   = 8'h00;
			hdr_disp = 8'h00;
			hdr_len  = 8'h00;
			id_lim   = 8'hFF;
			disp_lim = 8'hFF;
		end else begin
			if (m_tvalid && m_tready)
				check_beat();
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_ID_LIMIT)
					id_lim = pwdata[7:0];
				else
					disp_lim = pwdata[7:0];
			end
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
		end
		pending = deframed_q.size();
	end
endmodule

[tb/tb_top.sv]
// Testbench top for escaped_frame_receiver_crc16_top: drives byte-stuffed frames
// and APB limit writes, throttles the result stream and reports the verdict.
// Depends on efr_pkg, the block and efr_frame_checker.
module tb_top;
	import efr_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_BYTES  = 210;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tready = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'h0;
	logic        s_tready;
	logic        m_tvalid;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic [31:0] prdata;
	logic        pready;
	int          failures;
	int          pending;
	bit          throttle   = 1'b1;
	bit          noise_mode = 1'b0;
	int          items_sent = 0;
	int unsigned cycle_cnt  = 0;

	escaped_frame_receiver_crc16_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	efr_frame_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= !throttle || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[escaped_frame_receiver_crc16_top] ERROR");
			$finish;
		end
	end

	// frame builder CRC, sent low byte first so the receiver ends on a zero residue
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		return r;
	endfunction

	// header value clustered around the limit so both sides of the compare get hit
	function automatic logic [7:0] pick_header(input logic [7:0] limit);
		case ($urandom_range(7))
			0: return limit - 8'd1;
			1: return limit;
			2: return limit + 8'd1;
			3: return 8'h00;
			4: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] pick_payload();
		case ($urandom_range(9))
			0: return MARK_BYTE;
			1: return ESC_BYTE;
			2: return 8'($urandom_range(1));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// called and returns at a falling edge; leaves tvalid high for back-to-back beats
	task automatic send_byte(input logic [7:0] b);
		while (throttle && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (!noise_mode)
			items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [7:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= {24'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// start mark, header, payload, CRC, optional escape, end mark; bytes are stuffed on the way out
	task automatic send_frame(input logic [7:0] fid, input logic [7:0] fdisp,
			input logic [7:0] flen, input int body_len, input bit bad_crc, input bit esc_end);
		logic [7:0]  unstuffed[$];
		logic [15:0] crc;
		unstuffed = {fid, fdisp, flen};
		repeat (body_len) unstuffed.push_back(pick_payload());
		crc = CRC_INIT;
		foreach (unstuffed[i]) crc = crc16_update(crc, unstuffed[i]);
		if (bad_crc)
			crc ^= 16'h0001 << $urandom_range(15);
		unstuffed.push_back(crc[7:0]);
		unstuffed.push_back(crc[15:8]);
		send_byte(MARK_BYTE);
		foreach (unstuffed[i]) begin
			if (unstuffed[i] == MARK_BYTE || unstuffed[i] == ESC_BYTE ||
					(unstuffed[i] > 8'h01 && $urandom_range(19) == 0)) begin
				send_byte(ESC_BYTE);
				if ($urandom_range(3) == 0)
					send_byte(ESC_BYTE);
				send_byte(~unstuffed[i]);
			end else begin
				send_byte(unstuffed[i]);
			end
		end
		if (esc_end)
			send_byte(ESC_BYTE);
		send_byte(MARK_BYTE);
	endtask

	task automatic random_frame(input logic [7:0] id_lim, input logic [7:0] disp_lim);
		int kind, flen, body;
		logic [7:0] fid, fdisp;
		kind  = $urandom_range(99);
		fid   = pick_header(id_lim);
		fdisp = pick_header(disp_lim);
		if ($urandom_range(149) == 0)
			flen = $urandom_range(1) ? 251 : 255;
		else if ($urandom_range(9) == 0)
			flen = $urandom_range(13, 60);
		else
			flen = $urandom_range(0, 12);
		body = flen;
		if (kind >= 60 && kind < 70) begin
			// length field disagrees with what is sent
			body = flen + ($urandom_range(1) ? $urandom_range(1, 2) : -$urandom_range(1, 2));
			if (body < 0)
				body = flen + 1;
		end else if (kind >= 76 && kind < 82) begin
			// short frame; the next start mark closes it without a verdict
			send_byte(MARK_BYTE);
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 253)));
		end else if (kind >= 82 && kind < 88) begin
			noise_mode = 1'b1;
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 254)));
			noise_mode = 1'b0;
		end
		send_frame(fid, fdisp, 8'(flen), body, kind >= 70 && kind < 76,
			kind >= 88 && kind < 93);
	endtask

	initial begin
		logic [7:0] lim_id, lim_disp;
		int ph, target, mid;
		bit paused;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: bytes ignored while hunting
		noise_mode = 1'b1;
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(ESC_BYTE);
		noise_mode = 1'b0;
		// short frame restarts in place
		send_byte(MARK_BYTE);
		send_byte(8'h01);
		send_byte(MARK_BYTE);
		// escape on escape stores ~0x01, then another short frame
		send_byte(ESC_BYTE);
		send_byte(ESC_BYTE);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(MARK_BYTE);
		// minimal good frame, header all zero and empty payload
		send_frame(8'h00, 8'h00, 8'h00, 0, 1'b0, 1'b0);
		// end mark right after an escape; four bytes, verdict bad
		send_byte(MARK_BYTE);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(ESC_BYTE);
		send_byte(8'h00);
		send_byte(ESC_BYTE);
		send_byte(MARK_BYTE);

		for (ph = 0; ph < 6; ph++) begin
			drain_results();
			case (ph)
				0: begin lim_id = 8'h00; lim_disp = 8'h00; end
				1: begin lim_id = 8'hFF; lim_disp = 8'hFF; end
				2: begin lim_id = 8'h80; lim_disp = 8'h01; end
				3: begin lim_id = 8'h01; lim_disp = 8'h80; end
				default: begin
					lim_id   = 8'($urandom_range(255));
					lim_disp = 8'($urandom_range(255));
				end
			endcase
			apb_write(REG_ID_LIMIT, lim_id);
			apb_write(REG_DISP_LIMIT, lim_disp);
			throttle = (ph != 2);
			if (ph == 1) begin
				// largest frame that fits, then one that overflows
				send_frame(8'h00, 8'h00, 8'd251, 251, 1'b0, 1'b0);
				send_frame(8'h05, 8'h05, 8'd255, 255, 1'b0, 1'b0);
			end
			target = items_sent + PHASE_BYTES;
			mid    = items_sent + PHASE_BYTES / 2;
			paused = 1'b0;
			while (items_sent < target) begin
				if (!paused && items_sent >= mid) begin
					drain_results();
					paused = 1'b1;
				end
				random_frame(lim_id, lim_disp);
			end
		end

		drain_results();
		repeat (4 * DRAIN_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("[escaped_frame_receiver_crc16_top] OK");
		else
			$display("[escaped_frame_receiver_crc16_top] ERROR");
		$finish;
	end
endmodule
